@@ rtl/core/utf16_to_utf8_transcoder_macros.svh @@
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define U16U8_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define U16U8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/u16u8_pkg.sv @@
package u16u8_pkg;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CountW   = 3;
  localparam int unsigned IdxW     = 2;

  localparam logic [5:0]  HighSurrTag  = 6'h36;
  localparam logic [5:0]  LowSurrTag   = 6'h37;
  localparam logic [15:0] OneByteLimit = 16'h0080;
  localparam logic [15:0] TwoByteLimit = 16'h0800;
  localparam logic [20:0] SuppOffset   = 21'h10000;

  localparam logic [7:0] ContLead = 8'h80;
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;

  localparam logic [CountW-1:0] CountOne   = 3'd1;
  localparam logic [CountW-1:0] CountTwo   = 3'd2;
  localparam logic [CountW-1:0] CountThree = 3'd3;
  localparam logic [CountW-1:0] CountFour  = 3'd4;

  typedef struct packed {
    logic [CountW-1:0]         count;
    logic [MaxBytes-1:0][7:0]  bytes;
  } enc_res_t;

endpackage

@@ rtl/core/u16u8_encode.sv @@
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_encode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                big_endian_i,
  input  logic                accept_i,
  input  logic [7:0]          byte_first_i,
  input  logic [7:0]          byte_second_i,
  output u16u8_pkg::enc_res_t res_o
);

  logic        pending_high_q, pending_high_d;
  logic [9:0]  held_high_bits_q, held_high_bits_d;
  logic [15:0] unit;
  logic        is_high, is_low;
  logic [20:0] cp;

  always_comb begin
    unit    = big_endian_i ? {byte_first_i, byte_second_i} : {byte_second_i, byte_first_i};
    is_high = (unit[15:10] == u16u8_pkg::HighSurrTag);
    is_low  = (unit[15:10] == u16u8_pkg::LowSurrTag);
    cp      = {1'b0, held_high_bits_q, unit[9:0]} + u16u8_pkg::SuppOffset;

    res_o            = '0;
    pending_high_d   = pending_high_q;
    held_high_bits_d = held_high_bits_q;

    if (pending_high_q) begin
      pending_high_d = 1'b0;
      if (is_low) begin
        res_o.count    = u16u8_pkg::CountFour;
        res_o.bytes[0] = u16u8_pkg::Lead4 | {5'b0, cp[20:18]};
        res_o.bytes[1] = u16u8_pkg::ContLead | {2'b0, cp[17:12]};
        res_o.bytes[2] = u16u8_pkg::ContLead | {2'b0, cp[11:6]};
        res_o.bytes[3] = u16u8_pkg::ContLead | {2'b0, cp[5:0]};
      end
    end else if (is_high) begin
      pending_high_d   = 1'b1;
      held_high_bits_d = unit[9:0];
    end else if (unit < u16u8_pkg::OneByteLimit) begin
      res_o.count    = u16u8_pkg::CountOne;
      res_o.bytes[0] = unit[7:0];
    end else if (unit < u16u8_pkg::TwoByteLimit) begin
      res_o.count    = u16u8_pkg::CountTwo;
      res_o.bytes[0] = u16u8_pkg::Lead2 | {3'b0, unit[10:6]};
      res_o.bytes[1] = u16u8_pkg::ContLead | {2'b0, unit[5:0]};
    end else begin
      res_o.count    = u16u8_pkg::CountThree;
      res_o.bytes[0] = u16u8_pkg::Lead3 | {4'b0, unit[15:12]};
      res_o.bytes[1] = u16u8_pkg::ContLead | {2'b0, unit[11:6]};
      res_o.bytes[2] = u16u8_pkg::ContLead | {2'b0, unit[5:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_high_q   <= 1'b0;
      held_high_bits_q <= '0;
    end else if (accept_i) begin
      pending_high_q   <= pending_high_d;
      held_high_bits_q <= held_high_bits_d;
    end
  end

  `U16U8_ASSERT_SAME(a_four_needs_hold, res_o.count == u16u8_pkg::CountFour, pending_high_q, "four-byte result without held surrogate")
  `U16U8_ASSERT_NEXT(a_hold_clears, accept_i && pending_high_q, !pending_high_q, "surrogate hold survived next unit")

endmodule

@@ rtl/core/u16u8_serial.sv @@
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  u16u8_pkg::enc_res_t res_i,
  output logic                in_ready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [7:0]          m_tdata_o,
  output logic                m_tlast_o
);

  logic [u16u8_pkg::CountW-1:0]      count_q, count_d;
  logic [u16u8_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [u16u8_pkg::MaxBytes-1:0][7:0] bytes_q;
  logic                              last, out_hs;

  always_comb begin
    m_tvalid_o = (count_q != '0);
    last       = ({1'b0, idx_q} == (count_q - u16u8_pkg::CountOne));
    m_tdata_o  = bytes_q[idx_q];
    m_tlast_o  = last;
    out_hs     = m_tvalid_o && m_tready_i;
    in_ready_o = !m_tvalid_o || (out_hs && last);

    count_d = count_q;
    idx_d   = idx_q;
    if (load_i) begin
      count_d = res_i.count;
      idx_d   = '0;
    end else if (out_hs) begin
      if (last) begin
        count_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
    end
  end

  `U16U8_ASSERT_SAME(a_idx_in_range, m_tvalid_o, {1'b0, idx_q} < count_q, "byte index beyond result length")
  `U16U8_ASSERT_SAME(a_count_max, 1'b1, count_q <= u16u8_pkg::CountFour, "result length above four")
  `U16U8_ASSERT_NEXT(a_idx_advance, out_hs && !last && !load_i, m_tvalid_o && (idx_q == $past(idx_q) + 1'b1), "byte index did not advance")

endmodule

@@ rtl/core/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder.
// Slave side: one beat carries one UTF-16 code unit as two raw bytes in
// stream order; cfg_wdata_i written with cfg_we_i selects big-endian order.
// Master side: one UTF-8 byte per beat, tlast on the final byte of a unit
// (or of a surrogate pair). A high surrogate produces no beat; it is held
// and combined with the next unit, or dropped with it if that is no low
// surrogate.
// Latency: the first byte of a unit appears on the master side the cycle
// after the unit is accepted.
// Throughput: a unit holds the single result register until its last output
// byte (one to four bytes) is accepted; units that give no bytes leave it
// empty. The next unit is taken in the cycle the last byte of the previous
// one is accepted, so ASCII text runs at one unit per cycle while the
// receiver accepts every byte.
// Reset clears the held surrogate, the result count and index (not the result
// bytes) and selects little-endian order. When the receiver stalls, the
// current byte holds and s_axis_tready drops until its last byte is taken.
module utf16_to_utf8_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,   // big_endian
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] byte_first, [15:8] byte_second
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tlast
);

  logic                big_endian_q;
  logic                in_accept;
  u16u8_pkg::enc_res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  u16u8_encode u_encode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .big_endian_i  (big_endian_q),
    .accept_i      (in_accept),
    .byte_first_i  (s_axis_tdata[7:0]),
    .byte_second_i (s_axis_tdata[15:8]),
    .res_o         (res)
  );

  u16u8_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .res_i      (res),
    .in_ready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
